>>> hw/rtl/siec_pkg.sv
// ----------------------------------------------------------------------------
// siec_pkg: shared types and constants of the sorted interval event counter
// Store sizes, operation and status codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package siec_pkg;

  localparam int TIME_W    = 32;
  localparam int PT_DEPTH  = 1024;
  localparam int PT_AW     = $clog2(PT_DEPTH);
  localparam int PT_CW     = $clog2(PT_DEPTH + 1);
  localparam int IV_DEPTH  = 64;
  localparam int IV_AW     = $clog2(IV_DEPTH);
  localparam int IV_CW     = $clog2(IV_DEPTH + 1);
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 11;

  localparam logic [OP_W-1:0] OP_LOAD_POINT    = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_INTERVAL = 2'd1;
  localparam logic [OP_W-1:0] OP_RUN           = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_IV   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SKIP,
    S_COUNT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;       // apply a load operation from the input beat
    logic err_res;    // build the single error result
    logic clear;      // empty both stores and the error status
    logic run_start;  // first interval, pointers at zero
    logic skip_step;  // advance the scan pointer past an early point
    logic skip_done;  // remember the base and start counting
    logic cnt_step;   // count one point and advance
    logic res_load;   // capture the count of the current interval
    logic next_iv;    // move on to the next interval from the base
  } cmd_t;

  typedef struct packed {
    logic err_pending;
    logic iv_empty;
    logic skip_go;
    logic cnt_go;
    logic res_last;
  } stat_t;

endpackage

>>> hw/rtl/siec_ctrl.sv
// ----------------------------------------------------------------------------
// siec_ctrl: sequencer of the sorted interval event counter
// Accepts load and run beats, walks the two-pointer scan step by step and
// hands each count to the result channel.
// ----------------------------------------------------------------------------
module siec_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [siec_pkg::OP_W-1:0]     in_operation,
  input  logic                          out_ready,
  input  siec_pkg::stat_t               stat,
  output logic                          in_ready,
  output logic                          out_valid,
  output siec_pkg::cmd_t                cmd
);

  siec_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= siec_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      siec_pkg::S_IDLE: begin
        if (in_valid && in_operation == siec_pkg::OP_RUN) begin
          if (stat.err_pending) begin
            state_nxt = siec_pkg::S_OUT;
          end else if (!stat.iv_empty) begin
            state_nxt = siec_pkg::S_SKIP;
          end
        end
      end
      siec_pkg::S_SKIP: begin
        if (!stat.skip_go) begin
          state_nxt = siec_pkg::S_COUNT;
        end
      end
      siec_pkg::S_COUNT: begin
        if (!stat.cnt_go) begin
          state_nxt = siec_pkg::S_OUT;
        end
      end
      siec_pkg::S_OUT: begin
        if (out_ready) begin
          state_nxt = stat.res_last ? siec_pkg::S_IDLE : siec_pkg::S_SKIP;
        end
      end
      default: state_nxt = siec_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      siec_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_operation == siec_pkg::OP_RUN) begin
            if (stat.err_pending) begin
              cmd.err_res = 1'b1;
            end else if (stat.iv_empty) begin
              cmd.clear = 1'b1;
            end else begin
              cmd.run_start = 1'b1;
            end
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      siec_pkg::S_SKIP: begin
        if (stat.skip_go) begin
          cmd.skip_step = 1'b1;
        end else begin
          cmd.skip_done = 1'b1;
        end
      end
      siec_pkg::S_COUNT: begin
        if (stat.cnt_go) begin
          cmd.cnt_step = 1'b1;
        end else begin
          cmd.res_load = 1'b1;
        end
      end
      siec_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.res_last) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.next_iv = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> hw/rtl/siec_dp.sv
// ----------------------------------------------------------------------------
// siec_dp: stores, pointers and result register of the event counter
// Holds the point and interval memories, the fill totals, the error status,
// the scan and base pointers, the running count and the result beat.
// ----------------------------------------------------------------------------
module siec_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  siec_pkg::cmd_t                   cmd,
  input  logic [siec_pkg::OP_W-1:0]        in_operation,
  input  logic [siec_pkg::TIME_W-1:0]      in_point_time,
  input  logic [siec_pkg::TIME_W-1:0]      in_interval_start,
  input  logic [siec_pkg::TIME_W-1:0]      in_interval_end,
  output siec_pkg::stat_t                  stat,
  output logic [siec_pkg::IDX_W-1:0]       out_interval_index,
  output logic [siec_pkg::CNT_W-1:0]       out_event_count,
  output logic                             out_last,
  output logic [siec_pkg::STATUS_W-1:0]    out_status
);

  localparam int TW = siec_pkg::TIME_W;

  logic [TW-1:0]     pt_mem [siec_pkg::PT_DEPTH];
  logic [2*TW-1:0]   iv_mem [siec_pkg::IV_DEPTH];

  logic [TW-1:0]     pt_rd_r;
  logic [2*TW-1:0]   iv_rd_r;

  logic [siec_pkg::PT_CW-1:0]    pt_total_r, pt_total_nxt;
  logic [siec_pkg::IV_CW-1:0]    iv_total_r, iv_total_nxt;
  logic [siec_pkg::STATUS_W-1:0] err_r, err_nxt;
  logic [siec_pkg::PT_CW-1:0]    scan_r, scan_nxt;
  logic [siec_pkg::PT_CW-1:0]    base_r, base_nxt;
  logic [siec_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [siec_pkg::IV_AW-1:0]    iv_idx_r, iv_idx_nxt;

  logic [siec_pkg::IDX_W-1:0]    res_idx_r;
  logic [siec_pkg::CNT_W-1:0]    res_cnt_r;
  logic                          res_last_r;
  logic [siec_pkg::STATUS_W-1:0] res_status_r;

  logic                 pt_we, iv_we;
  logic                 pt_full, iv_full, iv_bad, scan_live, iv_is_last;
  logic [TW-1:0]        iv_start, iv_end;
  logic [siec_pkg::STATUS_W-1:0] load_err;

  assign iv_start   = iv_rd_r[2*TW-1:TW];
  assign iv_end     = iv_rd_r[TW-1:0];
  assign pt_full    = (pt_total_r >= siec_pkg::PT_CW'(siec_pkg::PT_DEPTH));
  assign iv_full    = (iv_total_r >= siec_pkg::IV_CW'(siec_pkg::IV_DEPTH));
  assign iv_bad     = (in_interval_end < in_interval_start);
  assign scan_live  = (scan_r < pt_total_r);
  assign iv_is_last = ({1'b0, iv_idx_r} + siec_pkg::IV_CW'(1) == iv_total_r);

  always_comb begin
    pt_we    = 1'b0;
    iv_we    = 1'b0;
    load_err = siec_pkg::ST_OK;
    if (cmd.load) begin
      case (in_operation)
        siec_pkg::OP_LOAD_POINT: begin
          if (pt_full) begin
            load_err = siec_pkg::ST_OVERFLOW;
          end else begin
            pt_we = 1'b1;
          end
        end
        siec_pkg::OP_LOAD_INTERVAL: begin
          if (iv_bad) begin
            load_err = siec_pkg::ST_BAD_IV;
          end else if (iv_full) begin
            load_err = siec_pkg::ST_OVERFLOW;
          end else begin
            iv_we = 1'b1;
          end
        end
        default: begin
          load_err = siec_pkg::ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    pt_total_nxt = pt_total_r;
    iv_total_nxt = iv_total_r;
    err_nxt      = err_r;
    scan_nxt     = scan_r;
    base_nxt     = base_r;
    cnt_nxt      = cnt_r;
    iv_idx_nxt   = iv_idx_r;
    if (pt_we) begin
      pt_total_nxt = pt_total_r + siec_pkg::PT_CW'(1);
    end
    if (iv_we) begin
      iv_total_nxt = iv_total_r + siec_pkg::IV_CW'(1);
    end
    // The first error of a load sequence is the one that is reported.
    if (err_r == siec_pkg::ST_OK) begin
      err_nxt = load_err;
    end
    if (cmd.run_start) begin
      scan_nxt   = '0;
      base_nxt   = '0;
      iv_idx_nxt = '0;
    end
    if (cmd.skip_step) begin
      scan_nxt = scan_r + siec_pkg::PT_CW'(1);
    end
    if (cmd.skip_done) begin
      base_nxt = scan_r;
      cnt_nxt  = '0;
    end
    if (cmd.cnt_step) begin
      scan_nxt = scan_r + siec_pkg::PT_CW'(1);
      cnt_nxt  = cnt_r + siec_pkg::CNT_W'(1);
    end
    if (cmd.next_iv) begin
      scan_nxt   = base_r;
      iv_idx_nxt = iv_idx_r + siec_pkg::IV_AW'(1);
    end
    if (cmd.clear) begin
      pt_total_nxt = '0;
      iv_total_nxt = '0;
      err_nxt      = siec_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_total_r <= '0;
      iv_total_r <= '0;
      err_r      <= siec_pkg::ST_OK;
      scan_r     <= '0;
      base_r     <= '0;
      cnt_r      <= '0;
      iv_idx_r   <= '0;
    end else begin
      pt_total_r <= pt_total_nxt;
      iv_total_r <= iv_total_nxt;
      err_r      <= err_nxt;
      scan_r     <= scan_nxt;
      base_r     <= base_nxt;
      cnt_r      <= cnt_nxt;
      iv_idx_r   <= iv_idx_nxt;
    end
  end

  // The read ports follow the next pointers, so the read data always
  // matches the current scan pointer and interval index.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_total_r[siec_pkg::PT_AW-1:0]] <= in_point_time;
    end
    pt_rd_r <= pt_mem[scan_nxt[siec_pkg::PT_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (iv_we) begin
      iv_mem[iv_total_r[siec_pkg::IV_AW-1:0]] <= {in_interval_start, in_interval_end};
    end
    iv_rd_r <= iv_mem[iv_idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.err_res) begin
      res_idx_r    <= '0;
      res_cnt_r    <= '0;
      res_last_r   <= 1'b1;
      res_status_r <= err_r;
    end else if (cmd.res_load) begin
      res_idx_r    <= siec_pkg::IDX_W'(iv_idx_r);
      res_cnt_r    <= cnt_r;
      res_last_r   <= iv_is_last;
      res_status_r <= siec_pkg::ST_OK;
    end
  end

  assign stat.err_pending = (err_r != siec_pkg::ST_OK);
  assign stat.iv_empty    = (iv_total_r == '0);
  assign stat.skip_go     = scan_live && (pt_rd_r < iv_start);
  assign stat.cnt_go      = scan_live && (pt_rd_r < iv_end);
  assign stat.res_last    = res_last_r;

  assign out_interval_index = res_idx_r;
  assign out_event_count    = res_cnt_r;
  assign out_last           = res_last_r;
  assign out_status         = res_status_r;

endmodule

>>> hw/rtl/sorted_interval_event_counter.sv
// ----------------------------------------------------------------------------
// sorted_interval_event_counter: counts sorted event times per interval
// Loads points and intervals, then on a run walks a two-pointer scan and
// returns one count per interval, or one error beat if a load failed.
// ----------------------------------------------------------------------------
//  channel  direction  ports
//  in_      input      in_valid, in_ready, in_operation, in_point_time,
//                      in_interval_start, in_interval_end
//  out_     output     out_valid, out_ready, out_interval_index,
//                      out_event_count, out_last, out_status
//
// A load beat is taken while the block is idle, and the block stays ready for
// the next. A run steps, per interval, over each point before the start, ends
// the skip, counts each point before the end, ends the count and offers the
// result beat, which is held until out_ready is high.
// The input is not ready again until the last result beat has been taken.
// Reset empties both stores and clears the error status at once.
// ----------------------------------------------------------------------------
module sorted_interval_event_counter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [siec_pkg::OP_W-1:0]        in_operation,
  input  logic [siec_pkg::TIME_W-1:0]      in_point_time,
  input  logic [siec_pkg::TIME_W-1:0]      in_interval_start,
  input  logic [siec_pkg::TIME_W-1:0]      in_interval_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [siec_pkg::IDX_W-1:0]       out_interval_index,
  output logic [siec_pkg::CNT_W-1:0]       out_event_count,
  output logic                             out_last,
  output logic [siec_pkg::STATUS_W-1:0]    out_status
);

  siec_pkg::cmd_t  cmd;
  siec_pkg::stat_t stat;

  siec_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_ready    (out_ready),
    .stat         (stat),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  siec_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_operation       (in_operation),
    .in_point_time      (in_point_time),
    .in_interval_start  (in_interval_start),
    .in_interval_end    (in_interval_end),
    .stat               (stat),
    .out_interval_index (out_interval_index),
    .out_event_count    (out_event_count),
    .out_last           (out_last),
    .out_status         (out_status)
  );

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted interval event counter
// Loads sorted and unsorted point and interval sets, runs the two-pointer
// count and compares every result beat with an in-bench prediction. Covers
// full and overflowing stores, bad intervals and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [siec_pkg::OP_W-1:0] OP_IGNORED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_ITEMS    = 200;
  localparam int TAIL_CYCLES     = 40;

  typedef struct packed {
    logic [siec_pkg::IDX_W-1:0]    index;
    logic [siec_pkg::CNT_W-1:0]    count;
    logic                          last;
    logic [siec_pkg::STATUS_W-1:0] status;
  } count_beat_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [siec_pkg::OP_W-1:0]     in_operation = '0;
  logic [siec_pkg::TIME_W-1:0]   in_point_time = '0;
  logic [siec_pkg::TIME_W-1:0]   in_interval_start = '0;
  logic [siec_pkg::TIME_W-1:0]   in_interval_end = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [siec_pkg::IDX_W-1:0]    out_interval_index;
  logic [siec_pkg::CNT_W-1:0]    out_event_count;
  logic                          out_last;
  logic [siec_pkg::STATUS_W-1:0] out_status;

  // Shadow copy of the block's stores and status.
  logic [siec_pkg::TIME_W-1:0]   point_mem [siec_pkg::PT_DEPTH];
  logic [siec_pkg::TIME_W-1:0]   span_lo [siec_pkg::IV_DEPTH];
  logic [siec_pkg::TIME_W-1:0]   span_hi [siec_pkg::IV_DEPTH];
  int unsigned                   points_held = 0;
  int unsigned                   spans_held = 0;
  logic [siec_pkg::STATUS_W-1:0] pending_status = siec_pkg::ST_OK;

  count_beat_t         expected_counts[$];
  int unsigned         fail_count = 0;
  int unsigned         beats_sent = 0;
  bit                  offering = 1'b0;
  bit                  steady = 1'b0;
  bit                  hold_off_req = 1'b0;
  bit                  holding = 1'b0;

  sorted_interval_event_counter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_point_time      (in_point_time),
    .in_interval_start  (in_interval_start),
    .in_interval_end    (in_interval_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_interval_index (out_interval_index),
    .out_event_count    (out_event_count),
    .out_last           (out_last),
    .out_status         (out_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void note_status(logic [siec_pkg::STATUS_W-1:0] code);
    // Only the first failure of a load phase is reported.
    if (pending_status == siec_pkg::ST_OK) pending_status = code;
  endfunction

  function automatic void predict_counts(logic [siec_pkg::OP_W-1:0] op,
                                         logic [siec_pkg::TIME_W-1:0] stamp,
                                         logic [siec_pkg::TIME_W-1:0] lo,
                                         logic [siec_pkg::TIME_W-1:0] hi);
    int unsigned scan;
    int unsigned base;
    int unsigned hits;
    count_beat_t beat;
    case (op)
      siec_pkg::OP_LOAD_POINT: begin
        if (points_held >= siec_pkg::PT_DEPTH) begin
          note_status(siec_pkg::ST_OVERFLOW);
        end else begin
          point_mem[points_held] = stamp;
          points_held++;
        end
      end
      siec_pkg::OP_LOAD_INTERVAL: begin
        if (hi < lo) begin
          note_status(siec_pkg::ST_BAD_IV);
        end else if (spans_held >= siec_pkg::IV_DEPTH) begin
          note_status(siec_pkg::ST_OVERFLOW);
        end else begin
          span_lo[spans_held] = lo;
          span_hi[spans_held] = hi;
          spans_held++;
        end
      end
      siec_pkg::OP_RUN: begin
        if (pending_status != siec_pkg::ST_OK) begin
          beat.index  = '0;
          beat.count  = '0;
          beat.last   = 1'b1;
          beat.status = pending_status;
          expected_counts.push_back(beat);
        end else begin
          base = 0;
          for (int k = 0; k < spans_held; k++) begin
            scan = base;
            hits = 0;
            while (scan < points_held && point_mem[scan] < span_lo[k]) scan++;
            base = scan;
            while (scan < points_held && point_mem[scan] < span_hi[k]) begin
              scan++;
              hits++;
            end
            beat.index  = siec_pkg::IDX_W'(k);
            beat.count  = siec_pkg::CNT_W'(hits);
            beat.last   = (k + 1 == spans_held);
            beat.status = siec_pkg::ST_OK;
            expected_counts.push_back(beat);
          end
        end
        points_held    = 0;
        spans_held     = 0;
        pending_status = siec_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic stop_offering();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic send_beat(input logic [siec_pkg::OP_W-1:0] op,
                           input logic [siec_pkg::TIME_W-1:0] stamp,
                           input logic [siec_pkg::TIME_W-1:0] lo,
                           input logic [siec_pkg::TIME_W-1:0] hi);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      stop_offering();
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_operation      <= op;
    in_point_time     <= stamp;
    in_interval_start <= lo;
    in_interval_end   <= hi;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_counts(op, stamp, lo, hi);
    if (op != OP_IGNORED) beats_sent++;
  endtask

  task automatic send_point(input logic [siec_pkg::TIME_W-1:0] stamp);
    send_beat(siec_pkg::OP_LOAD_POINT, stamp, $urandom, $urandom);
  endtask

  task automatic send_interval(input logic [siec_pkg::TIME_W-1:0] lo,
                               input logic [siec_pkg::TIME_W-1:0] hi);
    send_beat(siec_pkg::OP_LOAD_INTERVAL, $urandom, lo, hi);
  endtask

  task automatic send_run();
    send_beat(siec_pkg::OP_RUN, $urandom, $urandom, $urandom);
  endtask

  task automatic send_ignored();
    send_beat(OP_IGNORED, $urandom, $urandom, $urandom);
  endtask

  task automatic drain_counts();
    stop_offering();
    // The loop waits on the clock before its first check, so the drop of valid is seen before the next beat.
    do @(posedge clk); while (expected_counts.size() != 0);
  endtask

  task automatic test_directed_counts();
    // Duplicates, both time extremes, an empty interval and an all-ones end.
    send_point('0);
    send_point('0);
    send_point(32'd5);
    send_point(32'd9);
    send_point('1);
    send_interval('0, 32'd1);
    send_interval(32'd3, 32'd3);
    send_interval(32'd4, 32'd10);
    send_interval(32'd9, '1);
    send_interval('1, '1);
    send_ignored();
    send_run();
    // Intervals beyond the last point are still reported, with a zero count.
    send_point(32'd2);
    send_point(32'd3);
    send_interval('0, 32'd4);
    send_interval(32'd5, 32'd6);
    send_interval(32'd7, 32'd8);
    send_run();
    // Points but no intervals: the run clears the stores and returns nothing.
    send_point(32'd7);
    send_run();
    send_interval('0, '1);
    send_run();
    // An end before its start is dropped and reported on the next run.
    send_interval(32'd10, 32'd9);
    send_interval('0, 32'd5);
    send_point(32'd1);
    send_run();
  endtask

  task automatic test_full_stores();
    for (int i = 0; i < siec_pkg::PT_DEPTH; i++) send_point(siec_pkg::TIME_W'(i * 3));
    send_interval('0, '1);
    for (int k = 1; k < siec_pkg::IV_DEPTH; k++) begin
      send_interval(siec_pkg::TIME_W'(k * 48), siec_pkg::TIME_W'(k * 48 + 100));
    end
    send_run();
  endtask

  task automatic test_point_overflow();
    for (int i = 0; i <= siec_pkg::PT_DEPTH; i++) send_point(siec_pkg::TIME_W'(i * 7));
    send_interval('0, 32'd50);
    send_interval(32'd9, 32'd8);
    send_run();
  endtask

  task automatic test_interval_overflow();
    send_point(32'd1);
    for (int k = 0; k <= siec_pkg::IV_DEPTH; k++) begin
      send_interval(siec_pkg::TIME_W'(k), siec_pkg::TIME_W'(k + 2));
    end
    send_interval(32'd4, '0);
    send_run();
  endtask

  task automatic test_output_hold_off();
    steady = 1'b1;
    stop_offering();
    hold_off_req = 1'b1;
    while (!holding) @(posedge clk);
    // The first result fills the result register; later beats must wait for the stall.
    for (int i = 0; i < 16; i++) send_point(siec_pkg::TIME_W'(i * 10));
    for (int k = 0; k < 40; k++) begin
      send_interval(siec_pkg::TIME_W'(k * 4), siec_pkg::TIME_W'(k * 4 + 12));
    end
    send_run();
    for (int i = 0; i < 8; i++) send_point(siec_pkg::TIME_W'(i));
    send_interval(32'd2, 32'd6);
    send_run();
    steady = 1'b0;
  endtask

  task automatic test_sender_pause();
    drain_counts();
    send_point(32'd100);
    send_interval(32'd50, 32'd150);
    send_run();
  endtask

  task automatic send_sorted_batch();
    logic [siec_pkg::TIME_W-1:0] stamps[$];
    logic [siec_pkg::TIME_W-1:0] starts[$];
    longint unsigned   width;
    longint unsigned   floor_tick;
    longint unsigned   stop;
    int unsigned       n_pts;
    int unsigned       n_spans;
    bit                shuffled;
    // A window of random size and position keeps the times close enough
    // together for intervals to catch points.
    width      = (64'd1 << $urandom_range(3, 32)) - 1;
    floor_tick = $urandom_range(0, 32'(64'hFFFF_FFFF - width));
    n_pts      = $urandom_range(0, 24);
    n_spans    = $urandom_range(0, 12);
    shuffled   = ($urandom_range(0, 7) == 0);
    repeat (n_pts) begin
      stamps.push_back(siec_pkg::TIME_W'(floor_tick + $urandom_range(0, 32'(width))));
    end
    repeat (n_spans) begin
      starts.push_back(siec_pkg::TIME_W'(floor_tick + $urandom_range(0, 32'(width))));
    end
    if (!shuffled) begin
      stamps.sort();
      starts.sort();
    end
    foreach (stamps[i]) begin
      if ($urandom_range(0, 11) == 0) send_ignored();
      send_point(stamps[i]);
    end
    foreach (starts[k]) begin
      if ($urandom_range(0, 15) == 0 && starts[k] != 0) begin
        send_interval(starts[k],
                      starts[k] - siec_pkg::TIME_W'($urandom_range(1, 32'(starts[k]))));
      end else begin
        stop = starts[k] + $urandom_range(0, 32'(width >> 1));
        if (stop > 64'hFFFF_FFFF) stop = 64'hFFFF_FFFF;
        send_interval(starts[k], siec_pkg::TIME_W'(stop));
      end
    end
    send_run();
  endtask

  task automatic send_noise_burst();
    repeat ($urandom_range(2, 8))
      send_beat(siec_pkg::OP_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_sequences();
    int unsigned target;
    target = beats_sent + RANDOM_ITEMS;
    while (beats_sent < target) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) send_noise_burst();
      else send_sorted_batch();
      if ($urandom_range(0, 5) == 0) drain_counts();
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned span;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        holding = 1'b1;
        out_ready <= 1'b0;
        span = HOLD_OFF_CYCLES;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        span = steady ? 1 : $urandom_range(1, 6);
      end else begin
        out_ready <= 1'b0;
        span = 1 + pick_gap();
      end
      repeat (span - 1) @(posedge clk);
      holding = 1'b0;
    end
  end

  always @(posedge clk) begin : check_counts
    count_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        fail_count++;
        $error("result beat with nothing expected: index %0d count %0d last %0d status %0d",
               out_interval_index, out_event_count, out_last, out_status);
      end else begin
        want = expected_counts.pop_front();
        if (out_interval_index !== want.index) begin
          fail_count++;
          $error("out_interval_index: expected %0d, got %0d", want.index, out_interval_index);
        end
        if (out_event_count !== want.count) begin
          fail_count++;
          $error("out_event_count: expected %0d, got %0d", want.count, out_event_count);
        end
        if (out_last !== want.last) begin
          fail_count++;
          $error("out_last: expected %0d, got %0d", want.last, out_last);
        end
        if (out_status !== want.status) begin
          fail_count++;
          $error("out_status: expected %0d, got %0d", want.status, out_status);
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : sequencer
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_counts();
    test_full_stores();
    test_point_overflow();
    test_interval_overflow();
    test_output_hold_off();
    test_sender_pause();
    test_random_sequences();
    drain_counts();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sorted_interval_event_counter.f
hw/rtl/siec_pkg.sv
hw/rtl/siec_ctrl.sv
hw/rtl/siec_dp.sv
hw/rtl/sorted_interval_event_counter.sv
tb/testbench.sv
